// ===== hdl/tlqs_pkg.sv =====
// Shared types and constants of the two-level queue scheduler.
package tlqs_pkg;

  localparam logic [15:0] AGING_RST   = 16'd50;
  localparam logic [2:0]  QUANTUM_RST = 3'd5;

  localparam logic REG_AGING   = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  job_id;
    logic [15:0] run_length;
    logic        to_background;
  } in_word_t;

  typedef struct packed {
    logic       ran_valid;
    logic [7:0] ran_id;
    logic       ran_completed;
    logic [4:0] promoted_count;
    logic       add_rejected;
    logic       work_left;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] needed;
    logic [15:0] done;
    logic [31:0] stamp;
  } job_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic inc;
  } cell_ctl_t;

endpackage

// ===== hdl/tlqs_cell.sv =====
// One queue cell: holds a job, loads a new one, takes its upper neighbor's or counts up its done field.
module tlqs_cell (
  input  logic               clk,
  input  tlqs_pkg::cell_ctl_t ctl,
  input  tlqs_pkg::job_t     load_job,
  input  tlqs_pkg::job_t     upper_job,
  output tlqs_pkg::job_t     job
);
  import tlqs_pkg::*;

  job_t job_r, job_nxt;

  // Pick load, shift or increment of the done count
  always_comb begin
    job_nxt = job_r;
    if (ctl.load) begin
      job_nxt = load_job;
    end else if (ctl.shift) begin
      job_nxt = upper_job;
    end else if (ctl.inc) begin
      job_nxt.done = job_r.done + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job = job_r;
endmodule

// ===== hdl/tlqs_queue.sv =====
// FIFO built as a row of cells; head in cell 0, pop shifts the row down.
module tlqs_queue #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tlqs_pkg::job_t               push_job,
  input  logic                         pop,
  input  logic                         inc_head,
  output tlqs_pkg::job_t               head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import tlqs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] push_idx;
  job_t          cells [DEPTH];

  // Write slot moves down one when the row shifts in the same cycle
  assign push_idx = pop ? count_r - CW'(1) : count_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    job_t      upper;
    assign ctl.shift = pop;
    assign ctl.load  = push && (push_idx == CW'(i));
    assign ctl.inc   = inc_head && (i == 0);
    if (i == DEPTH - 1) begin : g_top
      assign upper = push_job;
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    tlqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_job  (push_job),
      .upper_job (upper),
      .job       (cells[i])
    );
  end

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cells[0];
  assign count = count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
endmodule

// ===== hdl/two_level_queue_scheduler_top.sv =====
// Top level: two cell-chain queues and the tick/add sequencer.
// Sequence: an add goes from S_IDLE to S_FIN; a tick goes through S_AGE, which
// promotes background jobs one per cycle, then through S_RUN and S_FIN.
// A new word is accepted only in S_IDLE, once the last one is through.
// Reset: rst_n synchronous low empties both queues, clears time and loads
// aging limit 50 and quantum 5; the receiver cannot stall out_valid.
module two_level_queue_scheduler_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tlqs_pkg::in_word_t  in_word,
  output logic                out_valid,
  output tlqs_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import tlqs_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_AGE, S_RUN, S_FIN} state_t;

  state_t    state_r;
  logic [31:0] tick_r;
  logic [15:0] aging_r;
  logic [2:0]  quantum_r;
  logic [2:0]  slice_r;
  out_word_t   res_r;
  logic        out_valid_r;

  logic          fg_push, fg_pop, fg_inc, bg_push, bg_pop;
  job_t          fg_push_job, bg_push_job, fg_head, bg_head;
  logic [CW-1:0] fg_count, bg_count;
  logic          fg_full, bg_full, aged, accept;
  logic [31:0]   age;
  logic [2:0]    q_eff;
  logic [3:0]    slice_inc;
  logic          fg_finish, bg_finish;
  logic [15:0]   fg_done_inc, bg_done_inc;

  assign accept  = start && state_r == S_IDLE;
  assign fg_full = fg_count == CW'(QUEUE_DEPTH);
  assign bg_full = bg_count == CW'(QUEUE_DEPTH);
  assign age     = tick_r - bg_head.stamp;
  assign aged    = bg_count != '0 && !fg_full && age > {16'd0, aging_r};
  assign q_eff   = (quantum_r == 3'd0) ? 3'd1 : quantum_r;
  assign slice_inc   = {1'b0, slice_r} + 4'd1;
  assign fg_done_inc = fg_head.done + 16'd1;
  assign bg_done_inc = bg_head.done + 16'd1;
  assign fg_finish   = fg_done_inc >= fg_head.needed;
  assign bg_finish   = bg_done_inc >= bg_head.needed;

  // Steer queue operations for add, aging and run steps
  always_comb begin
    fg_push     = 1'b0;
    fg_pop      = 1'b0;
    fg_inc      = 1'b0;
    bg_push     = 1'b0;
    bg_pop      = 1'b0;
    fg_push_job = '{id: in_word.job_id, needed: in_word.run_length,
                    done: 16'd0, stamp: tick_r};
    bg_push_job = fg_push_job;
    case (state_r)
      S_IDLE: begin
        if (accept && in_word.kind == KIND_ADD) begin
          fg_push = !in_word.to_background && !fg_full;
          bg_push = in_word.to_background && !bg_full;
        end
      end
      S_AGE: begin
        if (aged) begin
          fg_push     = 1'b1;
          fg_push_job = bg_head;
          bg_pop      = 1'b1;
        end
      end
      S_RUN: begin
        if (fg_count != '0) begin
          if (fg_finish) begin
            fg_pop = 1'b1;
          end else if (slice_inc >= {1'b0, q_eff}) begin
            fg_pop           = 1'b1;
            fg_push          = 1'b1;
            fg_push_job      = fg_head;
            fg_push_job.done = fg_done_inc;
          end else begin
            fg_inc = 1'b1;
          end
        end else if (bg_count != '0) begin
          bg_pop = bg_finish;
        end
      end
      default: ;
    endcase
  end

  tlqs_queue #(.DEPTH(QUEUE_DEPTH)) u_fg (
    .clk(clk), .rst_n(rst_n), .push(fg_push), .push_job(fg_push_job),
    .pop(fg_pop), .inc_head(fg_inc), .head(fg_head), .count(fg_count)
  );

  tlqs_queue #(.DEPTH(QUEUE_DEPTH)) u_bg (
    .clk(clk), .rst_n(rst_n), .push(bg_push), .push_job(bg_push_job),
    .pop(bg_pop),
    .inc_head(state_r == S_RUN && fg_count == '0 && bg_count != '0 && !bg_finish),
    .head(bg_head), .count(bg_count)
  );

  // Sequence the item, hold the result word and the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      aging_r     <= AGING_RST;
      quantum_r   <= QUANTUM_RST;
      slice_r     <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      out_valid_r <= (state_r == S_FIN);
      if (cfg_we) begin
        if (cfg_index == REG_AGING) begin
          aging_r <= cfg_wdata;
        end else begin
          quantum_r <= cfg_wdata[2:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_r <= '{ran_valid: 1'b0, ran_id: 8'd0, ran_completed: 1'b0,
                       promoted_count: 5'd0,
                       add_rejected: (in_word.kind == KIND_ADD) &&
                                     (in_word.to_background ? bg_full : fg_full),
                       work_left: 1'b0};
            if (in_word.kind != KIND_ADD) begin
              tick_r <= tick_r + 32'd1;
            end
            state_r <= (in_word.kind == KIND_ADD) ? S_FIN : S_AGE;
          end
        end
        S_AGE: begin
          if (aged) begin
            res_r.promoted_count <= res_r.promoted_count + 5'd1;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (fg_count != '0) begin
            res_r.ran_valid     <= 1'b1;
            res_r.ran_id        <= fg_head.id;
            res_r.ran_completed <= fg_finish;
            slice_r <= (fg_finish || slice_inc >= {1'b0, q_eff}) ? 3'd0 : slice_inc[2:0];
          end else if (bg_count != '0) begin
            res_r.ran_valid     <= 1'b1;
            res_r.ran_id        <= bg_head.id;
            res_r.ran_completed <= bg_finish;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Occupancy seen after the item settles
  logic work_left_r;
  always_ff @(posedge clk) begin
    work_left_r <= fg_count != '0 || bg_count != '0;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  always_comb begin
    out_word           = res_r;
    out_word.work_left = work_left_r;
  end

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result word while still busy");
  a_done_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word.ran_completed |-> out_word.ran_valid)
    else $error("completion without a run");
  a_add_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word.add_rejected |-> !out_word.ran_valid)
    else $error("rejected add reports a run");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the two-level queue scheduler: directed and random jobs and ticks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlqs_pkg::*;

  localparam int DEPTH = 16;

  // Track the scheduler's queues and predict one result word per input word.
  class sched_scoreboard;
    job_t        fg_q[$];
    job_t        bg_q[$];
    logic [2:0]  slice_used;
    logic [31:0] now;
    logic [15:0] aging_limit;
    logic [2:0]  quantum;
    out_word_t   pending[$];
    int          mismatches;

    function void clear();
      fg_q.delete();
      bg_q.delete();
      slice_used = '0;
      now = '0;
      aging_limit = AGING_RST;
      quantum = QUANTUM_RST;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == REG_AGING) aging_limit = val;
      else quantum = val[2:0];
    endfunction

    // Apply one accepted word and queue the word it should produce.
    function void note_input(in_word_t w);
      out_word_t r;
      job_t j;
      int q;
      r = '0;
      if (w.kind == KIND_ADD) begin
        j.id = w.job_id;
        j.needed = w.run_length;
        j.done = '0;
        j.stamp = now;
        if (w.to_background) begin
          if (bg_q.size() >= DEPTH) r.add_rejected = 1'b1;
          else bg_q.push_back(j);
        end else begin
          if (fg_q.size() >= DEPTH) r.add_rejected = 1'b1;
          else fg_q.push_back(j);
        end
      end else begin
        q = (quantum == 3'd0) ? 1 : int'(quantum);
        now = now + 32'd1;
        // Promote aged background heads while the foreground has room.
        while (bg_q.size() > 0 && fg_q.size() < DEPTH &&
               (now - bg_q[0].stamp) > {16'd0, aging_limit}) begin
          fg_q.push_back(bg_q.pop_front());
          r.promoted_count = r.promoted_count + 5'd1;
        end
        if (fg_q.size() > 0) begin
          fg_q[0].done = fg_q[0].done + 16'd1;
          slice_used = slice_used + 3'd1;
          r.ran_valid = 1'b1;
          r.ran_id = fg_q[0].id;
          if (fg_q[0].done >= fg_q[0].needed) begin
            r.ran_completed = 1'b1;
            void'(fg_q.pop_front());
            slice_used = '0;
          end else if (slice_used >= q) begin
            slice_used = '0;
            fg_q.push_back(fg_q.pop_front());
          end
        end else if (bg_q.size() > 0) begin
          bg_q[0].done = bg_q[0].done + 16'd1;
          r.ran_valid = 1'b1;
          r.ran_id = bg_q[0].id;
          if (bg_q[0].done >= bg_q[0].needed) begin
            r.ran_completed = 1'b1;
            void'(bg_q.pop_front());
          end
        end
      end
      r.work_left = (fg_q.size() > 0 || bg_q.size() > 0);
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.ran_valid !== exp_w.ran_valid || got.ran_id !== exp_w.ran_id ||
          got.ran_completed !== exp_w.ran_completed ||
          got.promoted_count !== exp_w.promoted_count ||
          got.add_rejected !== exp_w.add_rejected ||
          got.work_left !== exp_w.work_left) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h, got %h", exp_w, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_AGING;
  logic [15:0] cfg_wdata = '0;

  sched_scoreboard sb;

  two_level_queue_scheduler_top #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result word at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_word);
  end

  // Send one word after a random gap and hold it until accepted.
  // The block is busy after an accept, so the first edge of the wait never
  // costs a back-to-back slot.
  task automatic send_word(in_word_t w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_input(w);
    start <= 1'b0;
  endtask

  task automatic add_job(logic [7:0] id, logic [15:0] len, logic bg, bit no_gap);
    in_word_t w;
    w.kind = KIND_ADD;
    w.job_id = id;
    w.run_length = len;
    w.to_background = bg;
    send_word(w, no_gap);
  endtask

  task automatic tick(bit no_gap);
    in_word_t w;
    w = '0;
    w.kind = KIND_TICK;
    w.job_id = 8'($urandom);
    w.run_length = 16'($urandom);
    w.to_background = 1'($urandom);
    send_word(w, no_gap);
  endtask

  // Drain pending results, let the block settle, then write a register.
  task automatic write_reg(logic idx, logic [15:0] val);
    int guard;
    guard = 0;
    while (sb.pending.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (24) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Random phase: mostly short jobs, ticks often enough to finish them.
  task automatic random_phase(int n);
    logic [15:0] len;
    int burst;
    burst = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (burst == 0 && $urandom_range(0, 7) == 0) burst = 1;
      if ($urandom_range(0, 99) < 40) begin
        case ($urandom_range(0, 9))
          0: len = 16'($urandom);
          1: len = 16'hFFFF;
          2: len = 16'd0;
          default: len = 16'($urandom_range(1, 12));
        endcase
        add_job(8'($urandom), len, 1'($urandom), burst != 0);
      end else begin
        tick(burst != 0);
      end
      if ($urandom_range(0, 19) == 0) burst = (burst == 0) ? 1 : 0;
    end
  endtask

  initial begin
    int guard;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, field extremes, rotation, full queues, aging.
    tick(1'b0);
    add_job(8'hFF, 16'hFFFF, 1'b0, 1'b0);
    add_job(8'h00, 16'd0, 1'b1, 1'b0);
    add_job(8'hA5, 16'd1, 1'b1, 1'b1);
    repeat (7) tick(1'b1);
    for (int i = 0; i < 17; i++) add_job(8'(i), 16'd3, 1'b1, 1'b1);
    write_reg(REG_AGING, 16'd0);
    write_reg(REG_QUANTUM, 16'd0);
    tick(1'b0);
    tick(1'b0);
    for (int i = 0; i < 17; i++) add_job(8'(32'h40 + i), 16'd2, 1'b0, 1'b1);
    repeat (60) tick(1'b1);

    // Random phases across register settings, extremes included.
    write_reg(REG_AGING, 16'hFFFF);
    write_reg(REG_QUANTUM, 16'd7);
    random_phase(300);
    write_reg(REG_AGING, 16'd3);
    write_reg(REG_QUANTUM, 16'd1);
    random_phase(350);
    write_reg(REG_AGING, 16'($urandom_range(0, 40)));
    write_reg(REG_QUANTUM, 16'($urandom_range(0, 7)));
    random_phase(350);
    write_reg(REG_AGING, 16'd0);
    write_reg(REG_QUANTUM, 16'd4);
    random_phase(300);
    write_reg(REG_AGING, 16'd50);
    write_reg(REG_QUANTUM, 16'd2);
    random_phase(250);

    guard = 0;
    while (sb.pending.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
